### rtl/modbus_ascii_frame_decoder_defines.svh
// assertion macros used by the checker file
`ifndef MODBUS_ASCII_FRAME_DECODER_DEFINES_SVH
`define MODBUS_ASCII_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MAFD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MAFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mafd_pkg.sv
package mafd_pkg;

    // result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ADDRESS  = 2'd0;
    localparam kind_t KIND_FUNCTION = 2'd1;
    localparam kind_t KIND_DATA     = 2'd2;
    localparam kind_t KIND_STATUS   = 2'd3;

    // line status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_SHORT    = 3'd1;
    localparam status_t ST_NO_COLON = 3'd2;
    localparam status_t ST_EVEN     = 3'd3;
    localparam status_t ST_NON_HEX  = 3'd4;
    localparam status_t ST_LRC      = 3'd5;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [2:0] MIN_CHARS  = 3'd7;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // input beat
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        status_t    status_code;
        logic       last_result;
    } out_beat_t;

    // one queue entry: an optional byte and an optional end status
    typedef struct packed {
        logic       byte_vld;
        logic [7:0] byte_val;
        kind_t      byte_kind;
        logic       stat_vld;
        status_t    stat_code;
    } work_t;

    // uppercase hex digit decode: {is_hex, nibble}, nibble zero when not hex
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

### rtl/mafd_front.sv
module mafd_front
    import mafd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_beat_t in_beat,
    input  logic     q_full,
    output logic     q_push,
    output work_t    q_entry
);

    logic [2:0] char_count_reg,    char_count_next;
    logic       length_odd_reg,    length_odd_next;
    logic [3:0] high_nibble_reg,   high_nibble_next;
    logic [7:0] byte_sum_reg,      byte_sum_next;
    logic [7:0] pending_byte_reg,  pending_byte_next;
    logic       pending_valid_reg, pending_valid_next;
    kind_t      byte_position_reg, byte_position_next;
    status_t    error_code_reg,    error_code_next;

    logic       accept;
    logic       first_char;
    logic [4:0] hex;
    logic [7:0] new_byte;
    logic       emit_byte;
    status_t    line_status;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign first_char = (char_count_reg == 3'd0);
    assign hex        = hex_decode(in_beat.char_in);
    assign new_byte   = {high_nibble_reg, hex[3:0]};
    assign emit_byte  = !first_char && !length_odd_reg && pending_valid_reg;

    // per-character state update
    always_comb begin
        char_count_next    = char_count_reg;
        length_odd_next    = ~length_odd_reg;
        high_nibble_next   = high_nibble_reg;
        byte_sum_next      = byte_sum_reg;
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        byte_position_next = byte_position_reg;
        error_code_next    = error_code_reg;
        if (first_char) begin
            if (in_beat.char_in != CHAR_COLON) begin
                error_code_next = ST_NO_COLON;
            end
        end else begin
            if (!hex[4] && error_code_reg == ST_OK) begin
                error_code_next = ST_NON_HEX;
            end
            if (length_odd_reg) begin
                high_nibble_next = hex[3:0];
            end else begin
                if (pending_valid_reg && byte_position_reg != KIND_DATA) begin
                    byte_position_next = byte_position_reg + 2'd1;
                end
                pending_byte_next  = new_byte;
                pending_valid_next = 1'b1;
                byte_sum_next      = byte_sum_reg + new_byte;
            end
        end
        if (char_count_reg != MIN_CHARS) begin
            char_count_next = char_count_reg + 3'd1;
        end
    end

    // end-of-line status, error priority order
    always_comb begin
        priority if (char_count_next != MIN_CHARS) begin
            line_status = ST_SHORT;
        end else if (error_code_next == ST_NO_COLON) begin
            line_status = ST_NO_COLON;
        end else if (!length_odd_next) begin
            line_status = ST_EVEN;
        end else if (error_code_next == ST_NON_HEX) begin
            line_status = ST_NON_HEX;
        end else if (byte_sum_next != 8'd0) begin
            line_status = ST_LRC;
        end else begin
            line_status = ST_OK;
        end
    end

    // queue entry
    always_comb begin
        q_entry.byte_vld  = emit_byte;
        q_entry.byte_val  = pending_byte_reg;
        q_entry.byte_kind = byte_position_reg;
        q_entry.stat_vld  = in_beat.end_of_line;
        q_entry.stat_code = line_status;
        q_push            = accept && (emit_byte || in_beat.end_of_line);
    end

    // line state, cleared at end of line
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_beat.end_of_line)) begin
            char_count_reg    <= 3'd0;
            length_odd_reg    <= 1'b0;
            high_nibble_reg   <= 4'd0;
            byte_sum_reg      <= 8'd0;
            pending_byte_reg  <= 8'd0;
            pending_valid_reg <= 1'b0;
            byte_position_reg <= KIND_ADDRESS;
            error_code_reg    <= ST_OK;
        end else if (accept) begin
            char_count_reg    <= char_count_next;
            length_odd_reg    <= length_odd_next;
            high_nibble_reg   <= high_nibble_next;
            byte_sum_reg      <= byte_sum_next;
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            byte_position_reg <= byte_position_next;
            error_code_reg    <= error_code_next;
        end
    end

endmodule

### rtl/mafd_queue.sv
module mafd_queue
    import mafd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  work_t push_entry,
    input  logic  pop,
    output work_t head,
    output logic  full,
    output logic  not_empty
);

    work_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg,  count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/mafd_back.sv
module mafd_back
    import mafd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  work_t     head,
    input  logic      head_valid,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_beat
);

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_beat_reg,  out_beat_next;
    logic      byte_done_reg, byte_done_next;
    logic      load;
    logic      send_byte;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign send_byte = head.byte_vld && !byte_done_reg;

    // expand the head entry into one beat per cycle while the output register is not stalled
    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        out_beat_next  = out_beat_reg;
        byte_done_next = byte_done_reg;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = 1'b1;
            if (send_byte) begin
                out_beat_next.out_byte    = head.byte_val;
                out_beat_next.out_kind    = head.byte_kind;
                out_beat_next.status_code = ST_OK;
                out_beat_next.last_result = 1'b0;
                byte_done_next            = head.stat_vld;
                pop                       = !head.stat_vld;
            end else begin
                out_beat_next.out_byte    = 8'd0;
                out_beat_next.out_kind    = KIND_STATUS;
                out_beat_next.status_code = head.stat_code;
                out_beat_next.last_result = 1'b1;
                byte_done_next            = 1'b0;
                pop                       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            byte_done_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            byte_done_reg <= byte_done_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

### rtl/modbus_ascii_frame_decoder.sv
// path: a result beat passes a queue entry and then the output register; the end status
// follows its byte beat. throughput: one character per cycle unless the queue is full,
// one result beat per cycle unless the output is stalled; a four-entry queue decouples
// character intake from result delivery
// reset: aresetn synchronous active low, clears line state, queue and output valid
module modbus_ascii_frame_decoder
    import mafd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    logic  q_full;
    logic  q_push;
    work_t q_entry;
    logic  q_pop;
    work_t q_head;
    logic  q_not_empty;

    // character intake and line checking
    mafd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_beat  (s_beat),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decoupling queue
    mafd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .not_empty  (q_not_empty)
    );

    // result beat generation
    mafd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_beat   (m_beat)
    );

endmodule

### rtl/mafd_checker.sv
`include "modbus_ascii_frame_decoder_defines.svh"

module mafd_checker
    import mafd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_beat
);

    // a stalled result beat holds
    `MAFD_ASSERT_NEXT(a_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_beat),
        "result beat changed while stalled")

    // status beats carry a zero byte and the status kind
    `MAFD_ASSERT_NOW(a_status_form, aclk, aresetn,
        m_valid && m_beat.last_result,
        m_beat.out_kind == KIND_STATUS && m_beat.out_byte == 8'd0,
        "malformed status beat")

    // byte beats never carry the status kind or a status code
    `MAFD_ASSERT_NOW(a_byte_form, aclk, aresetn,
        m_valid && !m_beat.last_result,
        m_beat.out_kind != KIND_STATUS && m_beat.status_code == ST_OK,
        "malformed byte beat")

    // a result beat stays within the defined status codes
    `MAFD_ASSERT_NOW(a_code_range, aclk, aresetn,
        m_valid,
        m_beat.status_code <= ST_LRC,
        "status code out of range")

    // after a status beat leaves, the next beat cannot be a data byte
    `MAFD_ASSERT_NEXT(a_new_line, aclk, aresetn,
        m_valid && m_ready && m_beat.last_result,
        !m_valid || m_beat.last_result || m_beat.out_kind == KIND_ADDRESS,
        "line after status did not restart at address")

endmodule

bind modbus_ascii_frame_decoder mafd_checker u_mafd_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mafd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_WAIT    = 17;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_beat  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_beat;

    // expected result beats, oldest first
    out_beat_t   expected_beats[$];
    logic [7:0]  frame_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // idling control shared by the stimulus and the receiver
    bit sender_gaps   = 1'b0;
    bit receiver_gaps = 1'b0;
    bit hold_request  = 1'b0;

    // line state of the predictor
    logic [2:0] line_count;
    logic       line_odd;
    logic [3:0] line_high;
    logic [7:0] line_sum;
    logic [7:0] line_held;
    logic       line_held_vld;
    kind_t      line_kind;
    status_t    line_error;

    modbus_ascii_frame_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    always #5 aclk = ~aclk;

    // uppercase hex digit to {is_digit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = c - 8'h37;
        if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
        if (c inside {[8'h41:8'h46]}) return {1'b1, v[3:0]};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    // a character that is not an uppercase hex digit, nul and lowercase included
    function automatic logic [7:0] any_non_hex();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0: c = 8'h00;
            1: c = 8'h61 + 8'($urandom_range(0, 5));
            2: c = 8'($urandom_range(8'h01, 8'h2F));
            3: c = 8'($urandom_range(8'h3A, 8'h40));
            default: c = 8'($urandom_range(8'h47, 8'hFF));
        endcase
        return c;
    endfunction

    // mostly short payloads, now and then a long one
    function automatic int pick_data_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
    endfunction

    task automatic clear_line_state();
        line_count    = '0;
        line_odd      = 1'b0;
        line_high     = '0;
        line_sum      = '0;
        line_held     = '0;
        line_held_vld = 1'b0;
        line_kind     = KIND_ADDRESS;
        line_error    = ST_OK;
    endtask

    // decode one accepted character and queue the beats it causes
    task automatic predict_char(input logic [7:0] c, input logic eol);
        logic [4:0] dig;
        logic [7:0] assembled;
        out_beat_t  beat;
        status_t    verdict;
        if (line_count == 0) begin
            if (c != CHAR_COLON) line_error = ST_NO_COLON;
        end else begin
            dig = hex_digit(c);
            if (!dig[4] && line_error == ST_OK) line_error = ST_NON_HEX;
            if (line_odd) begin
                line_high = dig[3:0];
            end else begin
                assembled = {line_high, dig[3:0]};
                // the previous byte goes out once the next one completes
                if (line_held_vld) begin
                    beat.out_byte    = line_held;
                    beat.out_kind    = line_kind;
                    beat.status_code = ST_OK;
                    beat.last_result = 1'b0;
                    expected_beats   = {expected_beats, beat};
                    if (line_kind != KIND_DATA) line_kind = line_kind + 2'd1;
                end
                line_held     = assembled;
                line_held_vld = 1'b1;
                line_sum      = line_sum + assembled;
            end
        end
        if (line_count < MIN_CHARS) line_count = line_count + 3'd1;
        line_odd = ~line_odd;

        // end status in priority order
        if (eol) begin
            if (line_count < MIN_CHARS)         verdict = ST_SHORT;
            else if (line_error == ST_NO_COLON) verdict = ST_NO_COLON;
            else if (!line_odd)                 verdict = ST_EVEN;
            else if (line_error == ST_NON_HEX)  verdict = ST_NON_HEX;
            else if (line_sum != 8'h00)         verdict = ST_LRC;
            else                                verdict = ST_OK;
            beat.out_byte    = 8'h00;
            beat.out_kind    = KIND_STATUS;
            beat.status_code = verdict;
            beat.last_result = 1'b1;
            expected_beats   = {expected_beats, beat};
            clear_line_state();
        end
    endtask

    // offer one character and wait for it to be taken
    task automatic send_char(input logic [7:0] c, input logic eol);
        int        gap;
        in_beat_t  beat;
        gap = sender_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        beat.char_in     = c;
        beat.end_of_line = eol;
        s_valid <= 1'b1;
        s_beat  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_char(c, eol);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_chars.size(); i++) begin
            send_char(frame_chars[i], i == frame_chars.size() - 1);
        end
    endtask

    task automatic load_text(input string text);
        frame_chars = {};
        for (int i = 0; i < text.len(); i++) frame_chars = {frame_chars, text[i]};
    endtask

    // well-formed line: address, function, data and a matching lrc
    task automatic build_frame(input int n_data);
        logic [7:0] payload[$];
        logic [7:0] total;
        total = 8'h00;
        for (int i = 0; i < n_data + 2; i++) begin
            payload = {payload, 8'($urandom_range(0, 255))};
            total = total + payload[i];
        end
        payload = {payload, 8'h00 - total};
        frame_chars = {};
        frame_chars = {frame_chars, CHAR_COLON};
        foreach (payload[i]) begin
            frame_chars = {frame_chars, hex_char(payload[i][7:4])};
            frame_chars = {frame_chars, hex_char(payload[i][3:0])};
        end
    endtask

    // idling on or off per line, so some lines run back to back
    task automatic choose_idling();
        sender_gaps   = ($urandom_range(0, 3) != 0);
        receiver_gaps = ($urandom_range(0, 3) != 0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_frames();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        load_text(":0102FD");
        send_frame();
        load_text(":");
        send_frame();
        load_text("#0102FD");
        send_frame();
        load_text(":0102FDA");
        send_frame();
        load_text(":0102FD");
        frame_chars[3] = 8'h00;
        send_frame();
        load_text(":0102FE");
        send_frame();
    endtask

    task automatic test_good_frames(input int lines);
        repeat (lines) begin
            choose_idling();
            build_frame(pick_data_len());
            send_frame();
        end
    endtask

    task automatic test_short_lines(input int lines);
        int keep;
        repeat (lines) begin
            choose_idling();
            build_frame(0);
            keep = $urandom_range(1, 6);
            while (frame_chars.size() > keep) void'(frame_chars.pop_back());
            if ($urandom_range(0, 2) == 0) begin
                frame_chars[$urandom_range(0, keep - 1)] = 8'($urandom_range(0, 255));
            end
            send_frame();
        end
    endtask

    task automatic test_missing_colon(input int lines);
        logic [7:0] c;
        repeat (lines) begin
            choose_idling();
            build_frame(pick_data_len());
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_COLON) c = 8'h3B;
            frame_chars[0] = c;
            send_frame();
        end
    endtask

    task automatic test_even_length(input int lines);
        repeat (lines) begin
            choose_idling();
            build_frame(pick_data_len());
            if ($urandom_range(0, 1) == 0) void'(frame_chars.pop_back());
            else frame_chars = {frame_chars, hex_char(4'($urandom_range(0, 15)))};
            // even length outranks a bad digit
            if ($urandom_range(0, 3) == 0) begin
                frame_chars[$urandom_range(1, frame_chars.size() - 1)] = any_non_hex();
            end
            send_frame();
        end
    endtask

    task automatic test_non_hex(input int lines);
        repeat (lines) begin
            choose_idling();
            build_frame(pick_data_len());
            repeat ($urandom_range(1, 3)) begin
                frame_chars[$urandom_range(1, frame_chars.size() - 1)] = any_non_hex();
            end
            if ($urandom_range(0, 4) == 0) void'(frame_chars.pop_back());
            send_frame();
        end
    endtask

    task automatic test_lrc_mismatch(input int lines);
        int         pos;
        logic [4:0] dig;
        repeat (lines) begin
            choose_idling();
            build_frame(pick_data_len());
            // swap one digit for another hex digit
            pos = $urandom_range(1, frame_chars.size() - 1);
            dig = hex_digit(frame_chars[pos]);
            frame_chars[pos] = hex_char(dig[3:0] + 4'($urandom_range(1, 15)));
            send_frame();
        end
    endtask

    task automatic test_long_frames(input int lines);
        repeat (lines) begin
            choose_idling();
            build_frame($urandom_range(20, 40));
            send_frame();
        end
    endtask

    task automatic test_random_noise(input int lines);
        int len;
        repeat (lines) begin
            choose_idling();
            len = $urandom_range(1, 12);
            frame_chars = {};
            repeat (len) frame_chars = {frame_chars, 8'($urandom_range(0, 255))};
            if ($urandom_range(0, 1) == 0) frame_chars[0] = CHAR_COLON;
            send_frame();
        end
    endtask

    // receiver stops for a long stretch while lines keep coming
    task automatic test_backpressure();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        hold_request  = 1'b1;
        repeat (4) begin
            build_frame($urandom_range(10, 20));
            send_frame();
        end
        wait_drained();
    endtask

    // sender waits for every result before going on
    task automatic test_drain_pause(input int rounds);
        repeat (rounds) begin
            test_good_frames($urandom_range(1, 3));
            wait_drained();
        end
    endtask

    // receiver: per beat stall, plus a long hold when asked
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            stall = receiver_gaps ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result beat with the oldest expected one
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat expected none actual %h", $time, m_beat);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("out_byte", want.out_byte, m_beat.out_byte);
                check_field("out_kind", 8'(want.out_kind), 8'(m_beat.out_kind));
                check_field("status_code", 8'(want.status_code), 8'(m_beat.status_code));
                check_field("last_result", 8'(want.last_result), 8'(m_beat.last_result));
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no progress, %0d beats outstanding", $time, expected_beats.size());
            $display("modbus_ascii_frame_decoder regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_line_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_good_frames(20);
        test_short_lines(20);
        test_missing_colon(12);
        test_even_length(12);
        test_backpressure();
        test_non_hex(12);
        test_lrc_mismatch(12);
        test_long_frames(4);
        test_drain_pause(4);
        test_random_noise(30);
        test_good_frames(10);

        // let the last results arrive and idle before reporting
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("modbus_ascii_frame_decoder regression: pass");
        end else begin
            $display("modbus_ascii_frame_decoder regression: fail");
        end
        $finish;
    end

endmodule
